// ===== hw/rtl/sgu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sgu_pkg;

    localparam int FRAC      = 14;
    localparam int SAMPLE_W  = 16;
    localparam int AXES      = 3;
    localparam int TAPS      = 4;
    localparam int NUM_W     = SAMPLE_W + 5;
    localparam int MAG_W     = NUM_W - 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int STEPS     = FRAC + 1;
    localparam int ACC_W     = SUM_W + 2 * FRAC + 5;
    localparam int COMP_W    = FRAC + 1;
    localparam int OUT_W     = 16;
    localparam int FLOOR_W   = 16;
    localparam int FSQ_W     = 2 * FLOOR_W;
    localparam int THR_W     = FSQ_W + 8;
    localparam int DIM_W     = 2;
    localparam int FRONT_STAGES = 3;
    localparam int DEPTH     = FRONT_STAGES + STEPS + 1;
    localparam int IN_W      = AXES * TAPS * SAMPLE_W;
    localparam int OUTD_W    = AXES * OUT_W;

    // flat path: (mag + 6) / 12 == ((mag + 6) >> 2) / 3
    localparam int FY_W      = MAG_W - 1;
    localparam int RCP_SH    = 24;
    localparam int RCP_W     = 23;
    localparam logic [RCP_W-1:0] RCP3 = RCP_W'((2 ** RCP_SH + 2) / 3);
    localparam int FPROD_W   = FY_W + RCP_W;
    localparam logic [MAG_W:0] FLAT_RND = (MAG_W + 1)'(6);
    localparam logic [COMP_W-1:0] ONE = COMP_W'(2 ** FRAC);

    localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
    localparam logic REG_DIM   = 1'b0;
    localparam logic REG_FLOOR = 1'b1;
    localparam logic [DIM_W-1:0]   DIM_RESET   = 2'd3;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1;

    typedef struct packed {
        logic              neg;
        logic              flat;
        logic [SQ_W-1:0]   sq;
        logic [COMP_W-1:0] flat_mag;
    } t_lane_in;

    typedef struct packed {
        logic              neg;
        logic              flat;
        logic [COMP_W-1:0] search_mag;
        logic [COMP_W-1:0] flat_mag;
    } t_lane_res;

    function automatic logic signed [NUM_W-1:0] numer(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c,
        input logic signed [SAMPLE_W-1:0] d
    );
        logic signed [NUM_W-1:0] ea, eb, ec, ed;
        ea = NUM_W'(a);
        eb = NUM_W'(b);
        ec = NUM_W'(c);
        ed = NUM_W'(d);
        return ea - (eb <<< 3) + (ec <<< 3) - ed;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stencil_gradient_unit_normal_top.sv =====
// Throughput: one request per cycle while the master side accepts results; every axis
// has its own 15-step pipelined search for the normalized magnitude, one result bit
// per stage.
// Stages advance whenever the next stage is empty or advancing, so bubbles close up.
// Reset clears all stage valids, dimensions to 3 and norm_floor to 1.
`timescale 1ns / 1ps
`default_nettype none
module stencil_gradient_unit_normal_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [sgu_pkg::FLOOR_W-1:0]     i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // x_minus_two, x_minus_one, x_plus_one, x_plus_two, then y.., then z..
    input  wire logic [sgu_pkg::IN_W-1:0]        s_axis_tdata,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // normal_x, normal_y, normal_z
    output      logic [sgu_pkg::OUTD_W-1:0]      m_axis_tdata,
    // flat_flag
    output      logic                            m_axis_tuser
);
    localparam int D  = sgu_pkg::DEPTH;
    localparam int FS = sgu_pkg::FRONT_STAGES;

    logic [sgu_pkg::DIM_W-1:0]   r_dim;
    logic [sgu_pkg::FLOOR_W-1:0] r_floor;
    logic [D-1:0]                r_v;
    logic [D-1:0]                w_ld;
    logic [sgu_pkg::OUTD_W-1:0]  r_data;
    logic                        r_flag;

    sgu_pkg::t_lane_in  [sgu_pkg::AXES-1:0] w_lane_in;
    sgu_pkg::t_lane_res [sgu_pkg::AXES-1:0] w_lane_res;
    logic [sgu_pkg::SUM_W-1:0]              w_sum;
    logic [sgu_pkg::OUTD_W-1:0]             n_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= sgu_pkg::DIM_RESET;
            r_floor <= sgu_pkg::FLOOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgu_pkg::REG_DIM:   r_dim   <= i_cfg_data[sgu_pkg::DIM_W-1:0];
                sgu_pkg::REG_FLOOR: r_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor loads
    always_comb begin
        w_ld[D-1] = !r_v[D-1] || m_axis_tready;
        for (int i = D - 2; i >= 0; i--) begin
            w_ld[i] = !r_v[i] || w_ld[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < D; i++) begin
                if (w_ld[i]) begin
                    r_v[i] <= (i == 0) ? s_axis_tvalid : r_v[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    sgu_front u_front (
        .i_clk   (i_clk),
        .i_ld    (w_ld[FS-1:0]),
        .i_data  (s_axis_tdata),
        .i_is_2d (r_dim == sgu_pkg::DIM_2D),
        .i_floor (r_floor),
        .o_lane  (w_lane_in),
        .o_sum   (w_sum)
    );

    genvar g;
    generate
        for (g = 0; g < sgu_pkg::AXES; g++) begin : g_lane
            sgu_lane u_lane (
                .i_clk (i_clk),
                .i_ld  (w_ld[FS +: sgu_pkg::STEPS]),
                .i_in  (w_lane_in[g]),
                .i_sum (w_sum),
                .o_res (w_lane_res[g])
            );
        end
    endgenerate

    // merge: pick flat or normalized magnitude, restore sign
    always_comb begin
        logic [sgu_pkg::COMP_W-1:0] m;
        for (int i = 0; i < sgu_pkg::AXES; i++) begin
            m = w_lane_res[i].flat ? w_lane_res[i].flat_mag : w_lane_res[i].search_mag;
            n_data[i*sgu_pkg::OUT_W +: sgu_pkg::OUT_W] =
                w_lane_res[i].neg ? (sgu_pkg::OUT_W'(0) - sgu_pkg::OUT_W'(m))
                                  : sgu_pkg::OUT_W'(m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[D-1]) begin
            r_data <= n_data;
            r_flag <= w_lane_res[0].flat;
        end
    end

    assign s_axis_tready = w_ld[0];
    assign m_axis_tvalid = r_v[D-1];
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_flag;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_range_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16384 &&
                           $signed(m_axis_tdata[15:0]) >= -16384))
        else $error("normal_x out of range");

    a_nonflat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata != '0))
        else $error("non-flat result with zero normal");

    a_accept_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> s_axis_tready)
        else $error("empty input stage refused a request");

endmodule
`default_nettype wire

// ===== hw/rtl/sgu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sgu_front (
    input  wire logic                                    i_clk,
    input  wire logic [sgu_pkg::FRONT_STAGES-1:0]        i_ld,
    input  wire logic [sgu_pkg::IN_W-1:0]                i_data,
    input  wire logic                                    i_is_2d,
    input  wire logic [sgu_pkg::FLOOR_W-1:0]             i_floor,
    output      sgu_pkg::t_lane_in [sgu_pkg::AXES-1:0]   o_lane,
    output      logic [sgu_pkg::SUM_W-1:0]               o_sum
);
    localparam int SW = sgu_pkg::SAMPLE_W;

    logic [sgu_pkg::FSQ_W-1:0] r_fsq;
    logic [sgu_pkg::THR_W-1:0] r_thr;

    logic [sgu_pkg::MAG_W-1:0]   r_mag   [sgu_pkg::AXES];
    logic                        r_neg_a [sgu_pkg::AXES];
    logic [sgu_pkg::SQ_W-1:0]    r_sq_b  [sgu_pkg::AXES];
    logic [sgu_pkg::FPROD_W-1:0] r_fprod [sgu_pkg::AXES];
    logic                        r_neg_b [sgu_pkg::AXES];
    logic [sgu_pkg::SUM_W-1:0]   r_sum;
    logic                        r_flat;
    logic [sgu_pkg::SQ_W-1:0]    r_sq_c  [sgu_pkg::AXES];
    logic [sgu_pkg::COMP_W-1:0]  r_fmag  [sgu_pkg::AXES];
    logic                        r_neg_c [sgu_pkg::AXES];

    logic signed [sgu_pkg::NUM_W-1:0] w_num [sgu_pkg::AXES];
    logic [sgu_pkg::SUM_W-1:0]        w_sum;

    // 144 * floor^2; config must stay static while items flow, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_fsq <= i_floor * i_floor;
        r_thr <= (sgu_pkg::THR_W'(r_fsq) << 7) + (sgu_pkg::THR_W'(r_fsq) << 4);
    end

    always_comb begin
        for (int i = 0; i < sgu_pkg::AXES; i++) begin
            w_num[i] = sgu_pkg::numer(i_data[(4*i+0)*SW +: SW], i_data[(4*i+1)*SW +: SW],
                                      i_data[(4*i+2)*SW +: SW], i_data[(4*i+3)*SW +: SW]);
        end
        // drop z in 2-D
        if (i_is_2d) begin
            w_num[sgu_pkg::AXES-1] = '0;
        end
        w_sum = sgu_pkg::SUM_W'(r_sq_b[0]) + sgu_pkg::SUM_W'(r_sq_b[1])
              + sgu_pkg::SUM_W'(r_sq_b[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sgu_pkg::AXES; i++) begin
            if (i_ld[0]) begin
                r_neg_a[i] <= w_num[i][sgu_pkg::NUM_W-1];
                r_mag[i]   <= w_num[i][sgu_pkg::NUM_W-1] ? sgu_pkg::MAG_W'(-w_num[i])
                                                         : sgu_pkg::MAG_W'(w_num[i]);
            end
            if (i_ld[1]) begin
                r_neg_b[i] <= r_neg_a[i];
                r_sq_b[i]  <= r_mag[i] * r_mag[i];
                r_fprod[i] <= sgu_pkg::FY_W'(((sgu_pkg::MAG_W + 1)'(r_mag[i])
                                               + sgu_pkg::FLAT_RND) >> 2) * sgu_pkg::RCP3;
            end
            if (i_ld[2]) begin
                r_neg_c[i] <= r_neg_b[i];
                r_sq_c[i]  <= r_sq_b[i];
                if ((r_fprod[i] >> sgu_pkg::RCP_SH) > sgu_pkg::FPROD_W'(sgu_pkg::ONE)) begin
                    r_fmag[i] <= sgu_pkg::ONE;
                end else begin
                    r_fmag[i] <= sgu_pkg::COMP_W'(r_fprod[i] >> sgu_pkg::RCP_SH);
                end
            end
        end
        if (i_ld[2]) begin
            r_sum  <= w_sum;
            r_flat <= (w_sum == '0) || (w_sum < sgu_pkg::SUM_W'(r_thr));
        end
    end

    always_comb begin
        for (int i = 0; i < sgu_pkg::AXES; i++) begin
            o_lane[i].neg      = r_neg_c[i];
            o_lane[i].flat     = r_flat;
            o_lane[i].sq       = r_sq_c[i];
            o_lane[i].flat_mag = r_fmag[i];
        end
    end
    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ===== hw/rtl/sgu_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sgu_lane (
    input  wire logic                          i_clk,
    input  wire logic [sgu_pkg::STEPS-1:0]     i_ld,
    input  wire sgu_pkg::t_lane_in             i_in,
    input  wire logic [sgu_pkg::SUM_W-1:0]     i_sum,
    output      sgu_pkg::t_lane_res            o_res
);
    localparam int N = sgu_pkg::STEPS;
    localparam int W = sgu_pkg::ACC_W;

    // A = (2m-1)^2 S, B = (2m-1) S for the bits of m decided so far
    logic signed [W-1:0]         r_a    [N];
    logic signed [W-1:0]         r_b    [N];
    logic [sgu_pkg::SUM_W-1:0]   r_s    [N];
    logic [sgu_pkg::SQ_W-1:0]    r_sq   [N];
    logic [sgu_pkg::COMP_W-1:0]  r_m    [N];
    logic [sgu_pkg::COMP_W-1:0]  r_fmag [N];
    logic                        r_neg  [N];
    logic                        r_flat [N];

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_step
            localparam int K = N - 1 - j;
            logic signed [W-1:0]        w_a, w_b, w_s, w_r, w_cand;
            logic [sgu_pkg::SUM_W-1:0]  w_su;
            logic [sgu_pkg::SQ_W-1:0]   w_sq;
            logic [sgu_pkg::COMP_W-1:0] w_m, w_fmag;
            logic                       w_neg, w_flat, w_fit;

            if (j == 0) begin : g_head
                always_comb begin
                    w_su   = i_sum;
                    w_sq   = i_in.sq;
                    w_s    = $signed(W'(i_sum));
                    w_a    = w_s;
                    w_b    = -w_s;
                    w_m    = '0;
                    w_fmag = i_in.flat_mag;
                    w_neg  = i_in.neg;
                    w_flat = i_in.flat;
                end
            end else begin : g_body
                always_comb begin
                    w_su   = r_s[j-1];
                    w_sq   = r_sq[j-1];
                    w_s    = $signed(W'(r_s[j-1]));
                    w_a    = r_a[j-1];
                    w_b    = r_b[j-1];
                    w_m    = r_m[j-1];
                    w_fmag = r_fmag[j-1];
                    w_neg  = r_neg[j-1];
                    w_flat = r_flat[j-1];
                end
            end

            always_comb begin
                w_r    = $signed(W'(w_sq) << (2 * sgu_pkg::FRAC + 2));
                w_cand = w_a + (w_b <<< (K + 2)) + (w_s <<< (2 * K + 2));
                w_fit  = (w_cand <= w_r);
            end

            always_ff @(posedge i_clk) begin
                if (i_ld[j]) begin
                    r_a[j]    <= w_fit ? w_cand : w_a;
                    r_b[j]    <= w_fit ? (w_b + (w_s <<< (K + 1))) : w_b;
                    r_m[j]    <= w_fit ? (w_m | (sgu_pkg::COMP_W'(1) << K)) : w_m;
                    r_s[j]    <= w_su;
                    r_sq[j]   <= w_sq;
                    r_fmag[j] <= w_fmag;
                    r_neg[j]  <= w_neg;
                    r_flat[j] <= w_flat;
                end
            end
        end
    endgenerate

    assign o_res.neg        = r_neg[N-1];
    assign o_res.flat       = r_flat[N-1];
    assign o_res.search_mag = r_m[N-1];
    assign o_res.flat_mag   = r_fmag[N-1];

endmodule
`default_nettype wire

// ===== verif/stencil_gradient_unit_normal_top_tb.sv =====
`timescale 1ns / 1ps
module stencil_gradient_unit_normal_top_tb;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               flat;
    } t_normal;

    typedef struct {
        logic [sgu_pkg::IN_W-1:0] stim;
        bit                       typed;
        t_normal                  want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_idx = 1'b0;
    logic [sgu_pkg::FLOOR_W-1:0]   i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [sgu_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [sgu_pkg::OUTD_W-1:0]    m_axis_tdata;
    logic                          m_axis_tuser;

    logic [sgu_pkg::DIM_W-1:0]     dim_cfg = sgu_pkg::DIM_RESET;
    logic [sgu_pkg::FLOOR_W-1:0]   floor_cfg = sgu_pkg::FLOOR_RESET;
    t_normal                       pending_normals[$];
    t_row                          directed_rows[$];
    int                            errors = 0;
    int                            burst_left = 0;

    stencil_gradient_unit_normal_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_normal unit_normal(input logic [sgu_pkg::IN_W-1:0] stim);
        longint            n[3];
        longint unsigned   mag[3];
        longint unsigned   sum_sq;
        longint unsigned   m, lo, hi, mid, t;
        logic [127:0]      lhs, rhs;
        logic [15:0]       comp[3];
        bit                flat;
        t_normal           r;
        sum_sq = 0;
        for (int a = 0; a < sgu_pkg::AXES; a++) begin
            n[a] = longint'($signed(stim[64*a +: 16]))
                 - 8 * longint'($signed(stim[64*a+16 +: 16]))
                 + 8 * longint'($signed(stim[64*a+32 +: 16]))
                 - longint'($signed(stim[64*a+48 +: 16]));
            if (a == 2 && dim_cfg == sgu_pkg::DIM_2D)
                n[a] = 0;
            mag[a] = (n[a] < 0) ? longint'(-n[a]) : n[a];
            sum_sq += mag[a] * mag[a];
        end
        flat = (sum_sq == 0) ||
               (sum_sq < 64'd144 * longint'(floor_cfg) * longint'(floor_cfg));
        for (int a = 0; a < sgu_pkg::AXES; a++) begin
            if (flat) begin
                m = (mag[a] + 6) / 12;
                if (m > (64'd1 << sgu_pkg::FRAC))
                    m = 64'd1 << sgu_pkg::FRAC;
            end else begin
                // largest m with (m - 1/2) <= 2^F * |n| / sqrt(S)
                lo = 0;
                hi = 64'd1 << sgu_pkg::FRAC;
                rhs = 128'(mag[a] * mag[a]) << (2 * sgu_pkg::FRAC + 2);
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    t = 2 * mid - 1;
                    lhs = 128'(t * t) * 128'(sum_sq);
                    if (lhs <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                m = lo;
            end
            comp[a] = (n[a] < 0) ? 16'(-m) : 16'(m);
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.flat = flat;
        return r;
    endfunction

    // one axis: samples at -2, -1, +1, +2
    function automatic logic [63:0] axis(input int a, input int b, input int c, input int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic void add_row(input logic [sgu_pkg::IN_W-1:0] stim, input bit typed,
                                    input int nx, input int ny, input int nz, input bit flat);
        t_row r;
        r.stim = stim;
        r.typed = typed;
        r.want = '{16'(nx), 16'(ny), 16'(nz), flat};
        directed_rows.push_back(r);
    endfunction

    function automatic logic [15:0] pick_sample(input int mode, input int base);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 400) - 200);
            2: return 16'(base + $urandom_range(0, 2) - 1);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    function automatic logic [sgu_pkg::IN_W-1:0] random_stim();
        logic [sgu_pkg::IN_W-1:0] stim;
        int mode, base;
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 65535) - 32768;
        for (int k = 0; k < sgu_pkg::AXES * sgu_pkg::TAPS; k++)
            stim[16*k +: 16] = (mode == 2 && $urandom_range(0, 1)) ? 16'(base)
                                                                   : pick_sample(mode, base);
        return stim;
    endfunction

    // hold valid until the request is taken, then predict
    task automatic send_stim(input logic [sgu_pkg::IN_W-1:0] stim);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stim;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_normals.push_back(unit_normal(stim));
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain_and_configure(input int dim, input int floor_val);
        s_axis_tvalid <= 1'b0;
        while (pending_normals.size() != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= sgu_pkg::REG_DIM;
        i_cfg_data <= sgu_pkg::FLOOR_W'(dim);
        dim_cfg = sgu_pkg::DIM_W'(dim);
        @(negedge i_clk);
        i_cfg_idx <= sgu_pkg::REG_FLOOR;
        i_cfg_data <= sgu_pkg::FLOOR_W'(floor_val);
        floor_cfg = sgu_pkg::FLOOR_W'(floor_val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver: stall pattern switches now and then among four random modes
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ((rx_cycle % 6) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_normal got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tuser};
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = pending_normals.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                    got.flat !== want.flat) begin
                    $display({"%0t: mismatch expected x=%0d y=%0d z=%0d flat=%0b,",
                              " got x=%0d y=%0d z=%0d flat=%0b"},
                             $realtime, want.nx, want.ny, want.nz, want.flat,
                             got.nx, got.ny, got.nz, got.flat);
                    errors++;
                end
            end
        end
    end

    initial begin
        int phase_dim[8] = '{3, 2, 0, 1, 2, 3, 3, 2};
        int phase_floor[8] = '{1, 0, 65535, 100, 65535, 0, 7, 3000};
        add_row('0, 1, 0, 0, 0, 1);
        add_row({128'd0, axis(0, 0, 1, 0)}, 1, 1, 0, 0, 1);
        add_row({128'd0, axis(0, 0, 0, -6)}, 1, 1, 0, 0, 1);
        add_row({128'd0, axis(0, 0, 1000, 0)}, 1, 16384, 0, 0, 0);
        add_row({64'd0, axis(0, 1000, 0, 0), 64'd0}, 1, 0, -16384, 0, 0);
        add_row({axis(0, 0, 0, -32768), 128'd0}, 1, 0, 0, 16384, 0);
        add_row({3{axis(32767, 32767, 32767, 32767)}}, 1, 0, 0, 0, 1);
        add_row({3{axis(-32768, -32768, -32768, -32768)}}, 1, 0, 0, 0, 1);
        add_row({3{axis(32767, -32768, 32767, -32768)}}, 0, 0, 0, 0, 0);
        add_row({3{axis(-32768, 32767, -32768, 32767)}}, 0, 0, 0, 0, 0);
        add_row({axis(0, 0, 5, 0), axis(0, -3, 0, 0), axis(7, 0, 0, 0)}, 0, 0, 0, 0, 0);
        add_row({axis(1, 2, 3, 4), axis(-4, -3, -2, -1), axis(100, -50, 25, 9)},
                0, 0, 0, 0, 0);
        add_row({axis(0, 0, 0, 0), axis(0, 0, 0, 0), axis(1, 0, 0, 0)}, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            pace_sender();
            send_stim(directed_rows[k].stim);
            if (directed_rows[k].typed)
                pending_normals[pending_normals.size() - 1] = directed_rows[k].want;
        end

        for (int p = 0; p < 8; p++) begin
            drain_and_configure(phase_dim[p], phase_floor[p]);
            for (int k = 0; k < 212; k++) begin
                if (p == 3 && k == 100) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_normals.size() != 0) @(negedge i_clk);
                end
                pace_sender();
                send_stim(random_stim());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/sgu_pkg.sv
hw/rtl/sgu_front.sv
hw/rtl/sgu_lane.sv
hw/rtl/stencil_gradient_unit_normal_top.sv
verif/stencil_gradient_unit_normal_top_tb.sv
